### design/btl_pkg.sv
// Shared types, constants and helpers for the bitmap text layout block.
// Depends on nothing; every other file in the design imports it.
package btl_pkg;

    // Field widths of the input and result items.
    localparam int OPCODE_W  = 2;
    localparam int CODE_W    = 21;
    localparam int ADV_W     = 11;
    localparam int COLOR_W   = 32;
    localparam int POS_OUT_W = 16;
    localparam int EXT_W     = 15;
    localparam int LH_W      = 10;

    // Configuration port.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_HEIGHT   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_COLOR = 8'd1;
    localparam logic [LH_W-1:0]    LINE_HEIGHT_RST   = 10'd16;
    localparam logic [COLOR_W-1:0] INITIAL_COLOR_RST = 32'hFFFF_FFFF;

    // Parameter defaults.
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int POS_WIDTH_DEF     = 16;

    // Depth of the queue between front and back; must be a power of two.
    localparam int QUEUE_DEPTH = 4;

    // Character codes with a special meaning.
    localparam logic [CODE_W-1:0] CODE_CARET      = 21'h5E;
    localparam logic [CODE_W-1:0] CODE_NEWLINE    = 21'h0A;
    localparam logic [CODE_W-1:0] FIRST_PRINTABLE = 21'd32;
    localparam logic [CODE_W-1:0] CODE_DIGIT_0    = 21'h30;
    localparam logic [CODE_W-1:0] CODE_DIGIT_8    = 21'h38;
    localparam logic [CODE_W-1:0] CODE_ESC_WHITE  = 21'h46;

    localparam logic [EXT_W-1:0]   EXT_MAX     = 15'h7FFF;
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;

    // Input operations.
    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_CHAR  = 2'd1,
        OP_END   = 2'd2,
        OP_CLEAR = 2'd3
    } btl_op_t;

    // Result kinds.
    localparam logic KIND_GLYPH  = 1'b0;
    localparam logic KIND_EXTENT = 1'b1;

    // One classified item as it travels through the queue.
    typedef struct packed {
        btl_op_t                   op;
        logic [CODE_W-1:0]         code;
        logic signed [ADV_W-1:0]   adv;
        logic                      in_table;
        logic                      printable;
        logic                      caret;
        logic                      newline;
        logic                      esc_hit;
        logic [COLOR_W-1:0]        esc_color;
    } btl_entry_t;

    // Queue status seen by the back end.
    typedef struct packed {
        logic full;
        logic valid;
    } btl_qstat_t;

    // Flow control seen by the front end.
    typedef struct packed {
        logic queue_full;
        logic init_busy;
    } btl_front_ctl_t;

    // Configuration registers handed to the back end.
    typedef struct packed {
        logic [LH_W-1:0]    line_height;
        logic [COLOR_W-1:0] initial_color;
    } btl_cfg_t;

    // Palette for the escape digits '0' to '8' (RGBA, opaque alpha).
    function automatic logic [COLOR_W-1:0] palette_color(input logic [3:0] digit);
        logic [COLOR_W-1:0] c;
        case (digit)
            4'd0:    c = 32'h0000_00FF;
            4'd1:    c = 32'hFF00_00FF;
            4'd2:    c = 32'h00FF_00FF;
            4'd3:    c = 32'hFFFF_00FF;
            4'd4:    c = 32'h0000_FFFF;
            4'd5:    c = 32'h8000_80FF;
            4'd6:    c = 32'h00FF_FFFF;
            4'd7:    c = 32'h8080_80FF;
            4'd8:    c = 32'hD3D3_D3FF;
            default: c = COLOR_WHITE;
        endcase
        return c;
    endfunction

endpackage

### design/btl_front.sv
// Front end of the text layout block: accepts input transfers and
// classifies each item before it enters the queue. Depends on btl_pkg.
module btl_front #(
    parameter int TABLE_ENTRIES = btl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [btl_pkg::OPCODE_W-1:0]           s_opcode,
    input  logic [btl_pkg::CODE_W-1:0]             s_code,
    input  logic signed [btl_pkg::ADV_W-1:0]       s_glyph_advance,
    input  btl_pkg::btl_front_ctl_t                ctl,
    output logic                                   push,
    output btl_pkg::btl_entry_t                    push_entry
);
    import btl_pkg::*;

    logic digit_esc;
    logic white_esc;

    // Take a transfer whenever the queue has room and the table is usable.
    assign s_ready = !ctl.queue_full && !ctl.init_busy;
    assign push    = s_valid && s_ready;

    // Work out everything that depends on the code alone.
    assign digit_esc = (s_code >= CODE_DIGIT_0) && (s_code <= CODE_DIGIT_8);
    assign white_esc = (s_code == CODE_ESC_WHITE);

    always_comb begin
        push_entry.op        = btl_op_t'(s_opcode);
        push_entry.code      = s_code;
        push_entry.adv       = s_glyph_advance;
        push_entry.in_table  = int'(s_code) < TABLE_ENTRIES;
        push_entry.printable = s_code >= FIRST_PRINTABLE;
        push_entry.caret     = s_code == CODE_CARET;
        push_entry.newline   = s_code == CODE_NEWLINE;
        push_entry.esc_hit   = digit_esc || white_esc;
        push_entry.esc_color = digit_esc ? palette_color(s_code[3:0]) : COLOR_WHITE;
    end

endmodule

### design/btl_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on btl_pkg for the entry type and the depth.
module btl_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  btl_pkg::btl_entry_t     push_entry,
    input  logic                    pop,
    output btl_pkg::btl_entry_t     pop_entry,
    output btl_pkg::btl_qstat_t     q_stat
);
    import btl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    btl_entry_t        slot_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;

    // Pointers wrap naturally because the depth is a power of two.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry    = slot_mem[rd_ptr_reg];
    assign q_stat.full  = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign q_stat.valid = count_reg != '0;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

### design/btl_back.sv
// Back end of the text layout block: glyph table memory, cursor and
// colour state, and the result register. Depends on btl_pkg.
module btl_back #(
    parameter int TABLE_ENTRIES = btl_pkg::TABLE_ENTRIES_DEF,
    parameter int POS_WIDTH     = btl_pkg::POS_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  btl_pkg::btl_cfg_t                    cfg,
    input  btl_pkg::btl_qstat_t                  q_stat,
    input  btl_pkg::btl_entry_t                  q_entry,
    output logic                                 q_pop,
    output logic                                 init_busy,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_kind,
    output logic [btl_pkg::CODE_W-1:0]           m_glyph_code,
    output logic [btl_pkg::COLOR_W-1:0]          m_color,
    output logic signed [btl_pkg::POS_OUT_W-1:0] m_pos_x,
    output logic signed [btl_pkg::POS_OUT_W-1:0] m_pos_y,
    output logic [btl_pkg::EXT_W-1:0]            m_extent_width,
    output logic [btl_pkg::EXT_W-1:0]            m_extent_height
);
    import btl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};

    typedef enum logic [2:0] {
        S_SWEEP = 3'b001,
        S_FETCH = 3'b010,
        S_EXEC  = 3'b100
    } btl_state_t;

    btl_state_t state_reg, state_next;
    logic       init_busy_reg, init_busy_next;
    logic [IDX_W-1:0] sweep_idx_reg, sweep_idx_next;
    btl_entry_t cmd_reg;

    // Table memory: present bit over the glyph advance.
    logic [ADV_W:0]   table_mem [TABLE_ENTRIES];
    logic [ADV_W:0]   table_rd_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ADV_W:0]   mem_wdata;
    logic             rd_present;
    logic signed [ADV_W-1:0] rd_adv;

    // Layout state.
    logic                        esc_reg, esc_next;
    logic signed [POS_WIDTH-1:0] x_reg, x_next;
    logic signed [POS_WIDTH-1:0] y_reg, y_next;
    logic signed [POS_WIDTH-1:0] widest_reg, widest_next;
    logic [COLOR_W-1:0]          color_reg, color_next;

    // Result register.
    logic                     m_valid_reg, m_valid_next;
    logic                     kind_reg, kind_next;
    logic [CODE_W-1:0]        code_reg, code_next;
    logic [COLOR_W-1:0]       out_color_reg, out_color_next;
    logic signed [POS_OUT_W-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_OUT_W-1:0] pos_y_reg, pos_y_next;
    logic [EXT_W-1:0]         ext_w_reg, ext_w_next;
    logic [EXT_W-1:0]         ext_h_reg, ext_h_next;

    // Arithmetic.
    logic                        exec_go;
    logic                        glyph_hit;
    logic signed [POS_WIDTH:0]   x_sum;
    logic signed [POS_WIDTH:0]   y_sum;
    logic signed [POS_WIDTH-1:0] x_adv;
    logic signed [POS_WIDTH-1:0] y_adv;
    logic signed [32:0]          h_sum;
    logic signed [32:0]          w_ext;
    logic signed [LH_W:0]        lh_s;

    assign rd_present = table_rd_reg[ADV_W];
    assign rd_adv     = table_rd_reg[ADV_W-1:0];
    assign lh_s       = signed'({1'b0, cfg.line_height});

    // An item executes once the result register can take a new value.
    assign exec_go = (state_reg == S_EXEC) && !(m_valid_reg && !m_ready);
    assign q_pop   = (state_reg == S_FETCH) && q_stat.valid;
    assign glyph_hit = cmd_reg.printable && cmd_reg.in_table && rd_present;

    // Saturating cursor updates.
    assign x_sum = (POS_WIDTH+1)'(x_reg) + (POS_WIDTH+1)'(rd_adv);
    assign x_adv = (x_sum[POS_WIDTH] != x_sum[POS_WIDTH-1])
                 ? {x_sum[POS_WIDTH], {(POS_WIDTH-1){~x_sum[POS_WIDTH]}}}
                 : x_sum[POS_WIDTH-1:0];
    // y is never negative, so only the upper limit can be crossed.
    assign y_sum = (POS_WIDTH+1)'(y_reg) + (POS_WIDTH+1)'(lh_s);
    assign y_adv = y_sum[POS_WIDTH-1] ? POS_MAX : y_sum[POS_WIDTH-1:0];

    // Extents clamp to the unsigned 15-bit range.
    assign h_sum = 33'(y_reg) + 33'(lh_s);
    assign w_ext = 33'(widest_reg);

    // Memory write port: the clearing sweep or a glyph load.
    always_comb begin
        if (state_reg == S_SWEEP) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_idx_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = exec_go && (cmd_reg.op == OP_LOAD) && cmd_reg.in_table;
            mem_waddr = cmd_reg.code[IDX_W-1:0];
            mem_wdata = {1'b1, cmd_reg.adv};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop) begin
            table_rd_reg <= table_mem[q_entry.code[IDX_W-1:0]];
        end
    end

    // Sequencer: sweep, fetch with table read, then execute.
    always_comb begin
        state_next     = state_reg;
        init_busy_next = init_busy_reg;
        sweep_idx_next = sweep_idx_reg;
        case (state_reg)
            S_SWEEP: begin
                sweep_idx_next = sweep_idx_reg + IDX_W'(1);
                if (sweep_idx_reg == LAST_IDX) begin
                    state_next     = S_FETCH;
                    init_busy_next = 1'b0;
                end
            end
            S_FETCH: begin
                if (q_stat.valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    if (cmd_reg.op == OP_CLEAR) begin
                        state_next     = S_SWEEP;
                        sweep_idx_next = '0;
                    end else begin
                        state_next = S_FETCH;
                    end
                end
            end
            default: begin
                state_next = S_FETCH;
            end
        endcase
    end

    // Layout state and result for the item in execution.
    always_comb begin
        esc_next       = esc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        widest_next    = widest_reg;
        color_next     = color_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        kind_next      = kind_reg;
        code_next      = code_reg;
        out_color_next = out_color_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        ext_w_next     = ext_w_reg;
        ext_h_next     = ext_h_reg;
        if (exec_go) begin
            case (cmd_reg.op)
                OP_END: begin
                    m_valid_next   = 1'b1;
                    kind_next      = KIND_EXTENT;
                    code_next      = '0;
                    out_color_next = '0;
                    pos_x_next     = '0;
                    pos_y_next     = '0;
                    ext_w_next     = (w_ext > 33'sd32767) ? EXT_MAX : w_ext[EXT_W-1:0];
                    ext_h_next     = (h_sum > 33'sd32767) ? EXT_MAX : h_sum[EXT_W-1:0];
                    esc_next       = 1'b0;
                    x_next         = '0;
                    y_next         = '0;
                    widest_next    = '0;
                    color_next     = cfg.initial_color;
                end
                OP_CHAR: begin
                    if (esc_reg) begin
                        // The code after a caret is always consumed.
                        esc_next = 1'b0;
                        if (cmd_reg.esc_hit) begin
                            color_next = cmd_reg.esc_color;
                        end
                    end else if (cmd_reg.caret) begin
                        esc_next = 1'b1;
                    end else if (cmd_reg.newline) begin
                        x_next = '0;
                        y_next = y_adv;
                    end else if (glyph_hit) begin
                        m_valid_next   = 1'b1;
                        kind_next      = KIND_GLYPH;
                        code_next      = cmd_reg.code;
                        out_color_next = color_reg;
                        pos_x_next     = POS_OUT_W'(x_reg);
                        pos_y_next     = POS_OUT_W'(y_reg);
                        ext_w_next     = '0;
                        ext_h_next     = '0;
                        x_next         = x_adv;
                        if (x_adv > widest_reg) begin
                            widest_next = x_adv;
                        end
                    end
                end
                default: begin
                    // Loads and clears leave the layout state alone.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            init_busy_reg <= 1'b1;
            sweep_idx_reg <= '0;
            esc_reg       <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            widest_reg    <= '0;
            color_reg     <= INITIAL_COLOR_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_busy_reg <= init_busy_next;
            sweep_idx_reg <= sweep_idx_next;
            esc_reg       <= esc_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            widest_reg    <= widest_next;
            color_reg     <= color_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_entry;
        end
        kind_reg      <= kind_next;
        code_reg      <= code_next;
        out_color_reg <= out_color_next;
        pos_x_reg     <= pos_x_next;
        pos_y_reg     <= pos_y_next;
        ext_w_reg     <= ext_w_next;
        ext_h_reg     <= ext_h_next;
    end

    assign init_busy       = init_busy_reg;
    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_glyph_code    = code_reg;
    assign m_color         = out_color_reg;
    assign m_pos_x         = pos_x_reg;
    assign m_pos_y         = pos_y_reg;
    assign m_extent_width  = ext_w_reg;
    assign m_extent_height = ext_h_reg;

`ifndef SYNTH
    a_y_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        !y_reg[POS_WIDTH-1] && !widest_reg[POS_WIDTH-1])
        else $error("cursor y or widest x went negative");
    a_no_pop_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP) |-> !q_pop)
        else $error("item fetched during table sweep");
    a_extent_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_EXTENT) |->
            (m_pos_x == '0 && m_pos_y == '0 && m_color == '0 && m_glyph_code == '0))
        else $error("extent result carries placement fields");
    a_glyph_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_GLYPH) |->
            (m_extent_width == '0 && m_extent_height == '0))
        else $error("placement result carries extent fields");
`endif

endmodule

### design/bitmap_text_layout.sv
// Bitmap text layout: a front end accepts and classifies each input item
// into a four-entry queue, and a back end executes it in a fetch state that
// pops it and reads the glyph table memory, then an execute state that updates
// the cursor and loads the result register; it fetches no new item before the
// last one has executed. Results wait in an output register; while one waits
// without being taken, the back end can still fetch the next item but executes
// nothing until the result is taken. After reset the glyph table is swept clear
// with s_ready held low; a clear-table item costs another sweep in the back end
// while the front end keeps filling the queue. Configuration writes take effect
// at once and are expected only while the block is idle.
module bitmap_text_layout #(
    parameter int TABLE_ENTRIES = btl_pkg::TABLE_ENTRIES_DEF,
    parameter int POS_WIDTH     = btl_pkg::POS_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [btl_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [btl_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [btl_pkg::OPCODE_W-1:0]         s_opcode,
    input  logic [btl_pkg::CODE_W-1:0]           s_code,
    input  logic signed [btl_pkg::ADV_W-1:0]     s_glyph_advance,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_kind,
    output logic [btl_pkg::CODE_W-1:0]           m_glyph_code,
    output logic [btl_pkg::COLOR_W-1:0]          m_color,
    output logic signed [btl_pkg::POS_OUT_W-1:0] m_pos_x,
    output logic signed [btl_pkg::POS_OUT_W-1:0] m_pos_y,
    output logic [btl_pkg::EXT_W-1:0]            m_extent_width,
    output logic [btl_pkg::EXT_W-1:0]            m_extent_height
);
    import btl_pkg::*;

    logic [LH_W-1:0]    line_height_reg;
    logic [COLOR_W-1:0] initial_color_reg;
    btl_cfg_t           cfg;
    btl_front_ctl_t     front_ctl;
    btl_qstat_t         q_stat;
    btl_entry_t         push_entry;
    btl_entry_t         pop_entry;
    logic               push;
    logic               pop;
    logic               init_busy;

    // Configuration registers; writes to other indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_height_reg   <= LINE_HEIGHT_RST;
            initial_color_reg <= INITIAL_COLOR_RST;
        end else if (cfg_we) begin
            if (cfg_index == REG_LINE_HEIGHT) begin
                line_height_reg <= cfg_wdata[LH_W-1:0];
            end else if (cfg_index == REG_INITIAL_COLOR) begin
                initial_color_reg <= cfg_wdata[COLOR_W-1:0];
            end
        end
    end

    assign cfg.line_height      = line_height_reg;
    assign cfg.initial_color    = initial_color_reg;
    assign front_ctl.queue_full = q_stat.full;
    assign front_ctl.init_busy  = init_busy;

    btl_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_code          (s_code),
        .s_glyph_advance (s_glyph_advance),
        .ctl             (front_ctl),
        .push            (push),
        .push_entry      (push_entry)
    );

    btl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    btl_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .POS_WIDTH    (POS_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .q_stat          (q_stat),
        .q_entry         (pop_entry),
        .q_pop           (pop),
        .init_busy       (init_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_glyph_code    (m_glyph_code),
        .m_color         (m_color),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_extent_width  (m_extent_width),
        .m_extent_height (m_extent_height)
    );

endmodule
